[hw/rtl/rnht_pkg.sv]
package rnht_pkg;

	typedef enum logic [2:0] {
		CMD_ADD       = 3'd0,
		CMD_BUSY      = 3'd1,
		CMD_AVAIL     = 3'd2,
		CMD_BUSY_ALL  = 3'd3,
		CMD_AVAIL_ALL = 3'd4,
		CMD_LOOKUP    = 3'd5,
		CMD_REACH     = 3'd6
	} cmd_t;

	localparam logic [1:0] ST_AVAILABLE = 2'd0;
	localparam logic [1:0] ST_BUSY      = 2'd1;
	localparam logic [1:0] ST_EMPTY     = 2'd3;
	localparam logic [31:0] MAC_NONE    = 32'hFFFF_FFFF;
	localparam logic [7:0] PERF_WORST   = 8'hFF;

	typedef struct packed {
		logic [2:0]  command;
		logic [1:0]  port_index;
		logic [15:0] dest_net;
		logic [31:0] router_mac;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] next_hop_mac;
		logic [1:0]  next_hop_status;
		logic        table_full;
	} rsp_t;

	typedef struct packed {
		logic [31:0] mac;
		logic [1:0]  status;
		logic [7:0]  perf;
	} slot_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_CHECK,
		S_WRITE,
		S_RESP
	} state_t;

endpackage

[hw/rtl/rnht_stream_if.sv]
interface rnht_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/router_next_hop_table.sv]
// Per-port next-hop routing table. Each port owns ENTRIES_PER_PORT entries of a
// network number and two next-hop slots (mac, status, performance index) held in
// one memory with valid bits in flops. Every command walks the port's entries through
// a single registered read port and one compare unit: a read step and a compare step
// per entry visited, a write step for each entry rewritten by busy all or available
// all, plus accept, write and response steps. The result is held until taken, and
// no new request is accepted before then. Ports at or beyond PORT_COUNT answer a
// miss straight from the read step, without a compare. No clearing pass after reset.
module router_next_hop_table #(
	parameter int PORT_COUNT       = 4,
	parameter int ENTRIES_PER_PORT = 64
) (
	input  logic  clk,
	input  logic  arst_n,
	rnht_stream_if.sink   req,
	rnht_stream_if.source rsp
);
	import rnht_pkg::*;

	localparam int PW  = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
	localparam int EW  = $clog2(ENTRIES_PER_PORT);
	localparam int AW  = PW + EW;
	localparam int TOT = PORT_COUNT * ENTRIES_PER_PORT;
	localparam int IPW = 2;

	state_t state_q, state_d;
	req_t   req_q;
	rsp_t   rsp_q;
	rsp_t   rsp_wr;
	logic   [EW-1:0] idx_q;
	logic   found_q, free_ok_q, hit_q;
	logic   [EW-1:0] found_idx_q, free_idx_q;
	logic   [TOT-1:0] valid_q;

	logic [AW-1:0] raddr, waddr;
	logic [15:0]   rnet;
	slot_t         rs0, rs1, ws0, ws1;
	logic [15:0]   wnet;
	logic          we;

	req_t  in_req;
	assign in_req = req.payload;

	logic port_ok;
	logic [PW-1:0] port_sel;
	assign port_sel = PW'(req_q.port_index);
	assign port_ok  = ({{(32-IPW){1'b0}}, req_q.port_index} < 32'(PORT_COUNT));

	logic [EW-1:0] cur;
	assign cur = idx_q;
	assign raddr = {port_sel, (state_q == S_WRITE) ? found_idx_q : cur};
	logic [AW-1:0] cur_addr;
	assign cur_addr = {port_sel, cur};
	logic cur_valid;
	assign cur_valid = valid_q[cur_addr];

	rnht_entry_mem #(.AW(AW)) u_mem (
		.clk(clk), .raddr(raddr), .rnet(rnet), .rslot0(rs0), .rslot1(rs1),
		.we(we), .waddr(waddr), .wnet(wnet), .wslot0(ws0), .wslot1(ws1)
	);

	logic is_all, m0, m1, last;
	assign is_all = (req_q.command == CMD_BUSY_ALL) || (req_q.command == CMD_AVAIL_ALL);
	assign m0 = (rs0.mac == req_q.router_mac);
	assign m1 = !m0 && (rs1.mac == req_q.router_mac);
	assign last = (cur == EW'(ENTRIES_PER_PORT - 1));
	logic key_hit;
	assign key_hit = cur_valid && (rnet == req_q.dest_net);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (req.valid) state_d = S_READ;
			S_READ: begin
				if (!port_ok) state_d = S_RESP;
				else state_d = S_CHECK;
			end
			S_CHECK: begin
				if (is_all) begin
					if (cur_valid && (m0 || m1)) state_d = S_WRITE;
					else if (last) state_d = S_RESP;
					else state_d = S_READ;
				end else if (key_hit) state_d = S_WRITE;
				else if (last) state_d = (req_q.command == CMD_ADD) ? S_WRITE : S_RESP;
				else state_d = S_READ;
			end
			S_WRITE: begin
				if (is_all && !last) state_d = S_READ;
				else state_d = S_RESP;
			end
			S_RESP:  if (rsp.ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		we   = 1'b0;
		wnet = req_q.dest_net;
		ws0  = rs0;
		ws1  = rs1;
		waddr = {port_sel, found_idx_q};
		if (state_q == S_WRITE) begin
			case (req_q.command)
				CMD_ADD: begin
					if (!found_q) begin
						we    = free_ok_q;
						waddr = {port_sel, free_idx_q};
						ws0   = '{req_q.router_mac, ST_AVAILABLE, PERF_WORST};
						ws1   = '{MAC_NONE, ST_EMPTY, PERF_WORST};
					end else begin
						we   = 1'b1;
						wnet = rnet;
						if (m0) ws0.perf = rs0.perf - 8'(rs0.perf != 8'd0);
						else if (m1) ws1.perf = rs1.perf - 8'(rs1.perf != 8'd0);
						else if (rs0.perf <= rs1.perf)
							ws1 = '{req_q.router_mac, ST_AVAILABLE, PERF_WORST};
						else ws0 = '{req_q.router_mac, ST_AVAILABLE, PERF_WORST};
					end
				end
				CMD_BUSY, CMD_AVAIL, CMD_BUSY_ALL, CMD_AVAIL_ALL: begin
					we   = m0 || m1;
					wnet = rnet;
					if (is_all) waddr = cur_addr;
					if (m0) ws0.status = (req_q.command == CMD_BUSY ||
						req_q.command == CMD_BUSY_ALL) ? ST_BUSY : ST_AVAILABLE;
					if (m1) ws1.status = (req_q.command == CMD_BUSY ||
						req_q.command == CMD_BUSY_ALL) ? ST_BUSY : ST_AVAILABLE;
				end
				default: we = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			valid_q   <= '0;
			idx_q     <= '0;
			found_q   <= 1'b0;
			free_ok_q <= 1'b0;
			hit_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						req_q     <= in_req;
						idx_q     <= '0;
						found_q   <= 1'b0;
						free_ok_q <= 1'b0;
						hit_q     <= 1'b0;
					end
				end
				S_CHECK: begin
					if (!is_all && key_hit) begin
						found_q     <= 1'b1;
						found_idx_q <= cur;
					end
					if (!cur_valid && !free_ok_q) begin
						free_ok_q  <= 1'b1;
						free_idx_q <= cur;
					end
					if (!last && (is_all ? !(cur_valid && (m0 || m1)) : !key_hit))
						idx_q <= idx_q + 1'b1;
				end
				S_WRITE: begin
					if (is_all) begin
						hit_q <= 1'b1;
						idx_q <= idx_q + 1'b1;
					end
					if (req_q.command == CMD_ADD && !found_q && free_ok_q)
						valid_q[{port_sel, free_idx_q}] <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// result is formed in the write step from the entry read out in the check step
	always_comb begin
		rsp_wr = '{1'b0, 32'd0, ST_EMPTY, 1'b0};
		case (req_q.command)
			CMD_ADD: begin
				rsp_wr.hit        = found_q && (m0 || m1);
				rsp_wr.table_full = !found_q && !free_ok_q;
			end
			CMD_BUSY, CMD_AVAIL: rsp_wr.hit = m0 || m1;
			CMD_BUSY_ALL, CMD_AVAIL_ALL: rsp_wr.hit = 1'b1;
			CMD_LOOKUP: begin
				rsp_wr.hit = 1'b1;
				if (rs0.perf <= rs1.perf) begin
					rsp_wr.next_hop_mac    = rs0.mac;
					rsp_wr.next_hop_status = rs0.status;
				end else begin
					rsp_wr.next_hop_mac    = rs1.mac;
					rsp_wr.next_hop_status = rs1.status;
				end
			end
			CMD_REACH: rsp_wr.hit = (rs0.status == ST_AVAILABLE) ||
				(rs1.status == ST_AVAILABLE);
			default: rsp_wr.hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_READ && !port_ok) begin
			rsp_q <= '{1'b0, 32'd0, ST_EMPTY, 1'b0};
		end else if (state_q == S_CHECK && state_d == S_RESP) begin
			rsp_q <= '{hit_q, 32'd0, ST_EMPTY, 1'b0};
		end else if (state_q == S_WRITE) begin
			rsp_q <= rsp_wr;
		end
	end

	assign req.ready   = (state_q == S_IDLE);
	assign rsp.valid   = (state_q == S_RESP);
	assign rsp.payload = rsp_q;
endmodule

[hw/rtl/rnht_entry_mem.sv]
module rnht_entry_mem #(
	parameter int AW = 8
) (
	input  logic                 clk,
	input  logic [AW-1:0]        raddr,
	output logic [15:0]          rnet,
	output rnht_pkg::slot_t      rslot0,
	output rnht_pkg::slot_t      rslot1,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic [15:0]          wnet,
	input  rnht_pkg::slot_t      wslot0,
	input  rnht_pkg::slot_t      wslot1
);
	import rnht_pkg::*;

	localparam int DEPTH = 1 << AW;

	logic [15:0] net_mem [DEPTH];
	slot_t       s0_mem [DEPTH];
	slot_t       s1_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			net_mem[waddr] <= wnet;
			s0_mem[waddr]  <= wslot0;
			s1_mem[waddr]  <= wslot1;
		end
		rnet   <= net_mem[raddr];
		rslot0 <= s0_mem[raddr];
		rslot1 <= s1_mem[raddr];
	end
endmodule

[sim/tb_scoreboard.sv]
`timescale 1ns / 1ps
package tb_route_sb_pkg;
	import rnht_pkg::*;

	localparam int NUM_PORTS = 4;
	localparam int PORT_DEPTH = 64;

	class route_scoreboard;
		bit          valid_q [NUM_PORTS * PORT_DEPTH];
		logic [15:0] net_q [NUM_PORTS * PORT_DEPTH];
		slot_t       slot_q [2 * NUM_PORTS * PORT_DEPTH];
		rsp_t        expected_rsp [$];
		int          errors;
		int          checked;

		function int find_net(int port, logic [15:0] net);
			int e;
			for (int i = 0; i < PORT_DEPTH; i++) begin
				e = port * PORT_DEPTH + i;
				if (valid_q[e] && net_q[e] == net)
					return e;
			end
			return -1;
		endfunction

		function int slot_of(int e, logic [31:0] mac);
			if (slot_q[2 * e].mac == mac)
				return 2 * e;
			if (slot_q[2 * e + 1].mac == mac)
				return 2 * e + 1;
			return -1;
		endfunction

		function void note_request(req_t r);
			rsp_t x;
			int e;
			int s;
			int f;
			int p;
			x = '{hit: 1'b0, next_hop_mac: 32'd0, next_hop_status: ST_EMPTY, table_full: 1'b0};
			p = int'(r.port_index);
			if (p < NUM_PORTS) begin
				e = find_net(p, r.dest_net);
				case (r.command)
					CMD_ADD: begin
						if (e < 0) begin
							f = -1;
							for (int i = 0; i < PORT_DEPTH; i++)
								if (f < 0 && !valid_q[p * PORT_DEPTH + i])
									f = p * PORT_DEPTH + i;
							if (f < 0)
								x.table_full = 1'b1;
							else begin
								valid_q[f] = 1'b1;
								net_q[f] = r.dest_net;
								slot_q[2 * f] = '{r.router_mac, ST_AVAILABLE, PERF_WORST};
								slot_q[2 * f + 1] = '{MAC_NONE, ST_EMPTY, PERF_WORST};
							end
						end else begin
							s = slot_of(e, r.router_mac);
							if (s >= 0) begin
								x.hit = 1'b1;
								if (slot_q[s].perf != 0)
									slot_q[s].perf--;
							end else if (slot_q[2 * e].perf <= slot_q[2 * e + 1].perf)
								slot_q[2 * e + 1] = '{r.router_mac, ST_AVAILABLE, PERF_WORST};
							else
								slot_q[2 * e] = '{r.router_mac, ST_AVAILABLE, PERF_WORST};
						end
					end
					CMD_BUSY, CMD_AVAIL: begin
						if (e >= 0) begin
							s = slot_of(e, r.router_mac);
							if (s >= 0) begin
								x.hit = 1'b1;
								slot_q[s].status = (r.command == CMD_BUSY) ? ST_BUSY : ST_AVAILABLE;
							end
						end
					end
					CMD_BUSY_ALL, CMD_AVAIL_ALL: begin
						for (int i = 0; i < PORT_DEPTH; i++) begin
							f = p * PORT_DEPTH + i;
							if (valid_q[f]) begin
								s = slot_of(f, r.router_mac);
								if (s >= 0) begin
									x.hit = 1'b1;
									slot_q[s].status = (r.command == CMD_BUSY_ALL) ?
										ST_BUSY : ST_AVAILABLE;
								end
							end
						end
					end
					CMD_LOOKUP: begin
						if (e >= 0) begin
							s = (slot_q[2 * e].perf <= slot_q[2 * e + 1].perf) ? 2 * e : 2 * e + 1;
							x.hit = 1'b1;
							x.next_hop_mac = slot_q[s].mac;
							x.next_hop_status = slot_q[s].status;
						end
					end
					CMD_REACH: begin
						if (e >= 0 && (slot_q[2 * e].status == ST_AVAILABLE ||
							slot_q[2 * e + 1].status == ST_AVAILABLE))
							x.hit = 1'b1;
					end
					default: ;
				endcase
			end
			expected_rsp.push_back(x);
		endfunction

		function void check_response(rsp_t a);
			rsp_t x;
			if (expected_rsp.size() == 0) begin
				$display("%0t: unexpected beat, actual %h", $time, a);
				errors++;
				return;
			end
			x = expected_rsp.pop_front();
			checked++;
			if (a.hit !== x.hit) begin
				$display("%0t: hit expected %b actual %b", $time, x.hit, a.hit);
				errors++;
			end
			if (a.next_hop_mac !== x.next_hop_mac) begin
				$display("%0t: mac expected %h actual %h", $time, x.next_hop_mac, a.next_hop_mac);
				errors++;
			end
			if (a.next_hop_status !== x.next_hop_status) begin
				$display("%0t: status expected %0d actual %0d", $time, x.next_hop_status,
					a.next_hop_status);
				errors++;
			end
			if (a.table_full !== x.table_full) begin
				$display("%0t: full expected %b actual %b", $time, x.table_full, a.table_full);
				errors++;
			end
		endfunction
	endclass
endpackage

[sim/tb.sv]
`timescale 1ns / 1ps
module tb;
	import rnht_pkg::*;
	import tb_route_sb_pkg::*;

	logic clk;
	logic arst_n;
	bit   no_idle;
	int   sent;

	rnht_stream_if #(.payload_t(req_t)) req ();
	rnht_stream_if #(.payload_t(rsp_t)) rsp ();

	route_scoreboard sb;

	router_next_hop_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Some tests failed");
		$finish;
	end

	// response side with random stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready)
				sb.check_response(rsp.payload);
			rsp.ready <= no_idle || ($urandom_range(99) >= 33);
		end
	end

	task automatic send(cmd_t c, logic [1:0] p, logic [15:0] n, logic [31:0] m);
		req_t r;
		r = '{command: c, port_index: p, dest_net: n, router_mac: m};
		while (!no_idle && $urandom_range(99) < 33) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.payload <= r;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		sb.note_request(r);
		sent++;
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_rsp.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_mac();
		case ($urandom_range(5))
			0: return MAC_NONE;
			1: return 32'd0;
			default: return 32'h100 + $urandom_range(5);
		endcase
	endfunction

	initial begin
		logic [15:0] n;
		sb = new();
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.payload = '0;
		no_idle = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		send(CMD_LOOKUP, 2'd0, 16'd0, 32'd0);
		send(CMD_ADD, 2'd0, 16'hFFFF, 32'hFFFF_FFFF);
		send(CMD_ADD, 2'd0, 16'hFFFF, 32'h0);
		send(CMD_ADD, 2'd0, 16'hFFFF, 32'h0);
		send(CMD_LOOKUP, 2'd0, 16'hFFFF, 32'd0);
		send(CMD_ADD, 2'd0, 16'hFFFF, 32'h1234);
		send(CMD_BUSY, 2'd0, 16'hFFFF, 32'h0);
		send(CMD_REACH, 2'd0, 16'hFFFF, 32'd0);
		send(CMD_BUSY_ALL, 2'd0, 16'h0, 32'h1234);
		send(CMD_REACH, 2'd0, 16'hFFFF, 32'd0);
		send(CMD_AVAIL, 2'd0, 16'hFFFF, 32'h1234);
		send(CMD_AVAIL_ALL, 2'd0, 16'h0, 32'h0);
		send(CMD_ADD, 2'd3, 16'h0, 32'hA5A5_5A5A);
		send(CMD_BUSY, 2'd3, 16'h0, 32'hFFFF_FFFF);
		send(CMD_LOOKUP, 2'd3, 16'h0, 32'd0);
		send(cmd_t'(3'd7), 2'd1, 16'h5555, 32'h5555_5555);
		send(CMD_REACH, 2'd2, 16'hAAAA, 32'hAAAA_AAAA);
		// fill port 1 until full, saturation via repeated adds
		for (int i = 0; i < 66; i++)
			send(CMD_ADD, 2'd1, 16'(i), 32'h200 + i);
		for (int i = 0; i < 260; i++)
			send(CMD_ADD, 2'd2, 16'h7, 32'h77);
		send(CMD_LOOKUP, 2'd2, 16'h7, 32'd0);
		drain();

		// random
		for (int k = 0; k < 960; k++) begin
			no_idle = (k >= 300 && k < 450);
			if (k == 500)
				drain();
			n = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(11));
			case ($urandom_range(9))
				0, 1, 2: send(CMD_ADD, 2'($urandom), n, pick_mac());
				3: send(CMD_BUSY, 2'($urandom), n, pick_mac());
				4: send(CMD_AVAIL, 2'($urandom), n, pick_mac());
				5: send($urandom_range(1) ? CMD_BUSY_ALL : CMD_AVAIL_ALL,
					2'($urandom), n, pick_mac());
				6, 7: send(CMD_LOOKUP, 2'($urandom), n, 32'($urandom));
				8: send(CMD_REACH, 2'($urandom), n, 32'($urandom));
				default: send(cmd_t'($urandom_range(7)), 2'($urandom), 16'($urandom),
					32'($urandom));
			endcase
		end
		drain();
		repeat (300) @(posedge clk);
		$display("covered %0d commands over all ports with %0d results checked", sent,
			sb.checked);
		$display("including full tables, index saturation and broadcast status updates");
		if (sb.errors == 0 && sb.expected_rsp.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
